// File: sv/lmpw_pkg.sv
// Shared constants, codes and types for the LED matrix pixel writer.
package lmpw_pkg;

    // Number of 8x8 driver units on the chain (1 to 4).
    localparam int UNITS  = 4;
    localparam int LINES  = 8 * UNITS;
    localparam int LINE_W = $clog2(LINES);
    localparam int UNIT_W = (UNITS > 1) ? $clog2(UNITS) : 1;

    // Request codes.
    typedef enum logic [1:0] {
        ACT_LINE   = 2'd0,
        ACT_ON     = 2'd1,
        ACT_OFF    = 2'd2,
        ACT_TOGGLE = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ROTATION = 2'd0,
        CFG_SIDE     = 2'd1,
        CFG_REVERSE  = 2'd2,
        CFG_HOLD     = 2'd3
    } t_cfg_idx;

    // Driver register address of a padding word.
    localparam logic [3:0] REG_NOOP = 4'd0;

endpackage

// File: sv/lmpw_in_if.sv
// Request channel of the LED matrix pixel writer.
interface lmpw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] line_index;
    logic [7:0] line_bits;

    modport source (output valid, action, pos_x, pos_y, line_index, line_bits,
                    input ready);
    modport sink   (input valid, action, pos_x, pos_y, line_index, line_bits,
                    output ready);
endinterface

// File: sv/lmpw_out_if.sv
// Chain word channel of the LED matrix pixel writer.
interface lmpw_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] reg_addr;
    logic [7:0] reg_value;
    logic       load_mark;

    modport source (output valid, reg_addr, reg_value, load_mark, input ready);
    modport sink   (input valid, reg_addr, reg_value, load_mark, output ready);
endinterface

// File: sv/led_matrix_pixel_writer_top.sv
// LED matrix pixel writer: line store, pixel mapping and chain word sequencer.
//
// Keeps a store of 8*UNITS native lines for a chain of 8x8 LED driver units
// and turns pixel on/off/toggle requests (by x and y) or direct line writes
// into chain words. A pixel is mapped to a line and a bit by the rotation,
// side-by-side and reverse-order registers. Out-of-range requests, and pixel
// requests that would not change the pixel, are dropped with no output. Each
// change produces UNITS words, farthest unit first: the addressed unit gets
// its digit register (1..8) and the line's new bits, every other unit a no-op
// word, and the last word (unit 0) has load_mark set. With hold_output set
// the store is still updated but no words are sent. The block takes one
// request at a time and drops ready until the transaction is fully done.
// A line write goes straight to the write state and then sends its chain
// words; a pixel request first reads and modifies the line. A range reject
// leaves the block idle, and a pixel already in that state is dropped in the
// modify step. The order is set by the single-port line store (read,
// modify, write) and by the output sequencer, which sends one word per cycle
// while the sink is ready. After reset the store reads as all zero through
// per-line valid bits; no clearing pass is needed.
// Configuration writes are expected only while the block is idle.
module led_matrix_pixel_writer_top
    import lmpw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    lmpw_in_if.sink          i_in,
    lmpw_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [1:0]       i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MOD,
        S_WRITE,
        S_EMIT
    } t_state;

    localparam logic [7:0] LINES8 = 8'(LINES);
    localparam logic [7:0] UTOP8  = 8'(UNITS - 1);
    localparam logic       MULTI  = (UNITS > 1);

    // Configuration registers.
    logic [1:0] r_rotation;
    logic       r_side;
    logic       r_reverse;
    logic       r_hold;

    // Sequencer state and working registers.
    t_state            r_state;
    logic [LINE_W-1:0] r_line;
    logic [2:0]        r_bit;
    t_action           r_action;
    logic [7:0]        r_new;
    logic [UNIT_W-1:0] r_unit;
    logic [LINES-1:0]  r_valid;
    logic              r_rd_vld;
    logic              r_out_valid;
    logic [3:0]        r_out_addr;
    logic [7:0]        r_out_value;
    logic              r_out_mark;

    // Line store.
    logic [7:0] r_mem [LINES];
    logic [7:0] r_rd_mem;

    // ------------------------------------------------------------------
    // Pixel to line/bit mapping (evaluated on the request at the port).
    // ------------------------------------------------------------------
    logic       sbs, horiz, rot0, rot1, rot3, rev;
    logic [4:0] bq, p, q;
    logic [2:0] map_bit, map_lo;
    logic [7:0] wide, narrow, xmax, ymax, top, map_line;
    logic       pix_ok, line_ok;

    always_comb begin
        sbs   = r_side & MULTI;
        horiz = ~r_rotation[0];
        rot0  = (r_rotation == 2'd0);
        rot1  = (r_rotation == 2'd1);
        rot3  = (r_rotation == 2'd3);
        bq    = horiz ? i_in.pos_x : i_in.pos_y;
        map_bit = (rot0 | rot3) ? ~bq[2:0] : bq[2:0];
        if (sbs) begin
            rev = ((rot0 | rot1) == ~r_reverse);
            p   = horiz ? i_in.pos_y : i_in.pos_x;
            q   = p;
        end else begin
            rev = ~((rot0 | rot3) == ~r_reverse);
            p   = horiz ? i_in.pos_x : i_in.pos_y;
            q   = horiz ? i_in.pos_y : i_in.pos_x;
        end
        top = rev ? ((UTOP8 - 8'(p[4:3])) << 3) : {3'b000, p[4:3], 3'b000};
        map_lo   = (rot0 | rot1) ? q[2:0] : ~q[2:0];
        map_line = top + 8'(map_lo);
        wide   = sbs ? 8'd8 : LINES8;
        narrow = sbs ? LINES8 : 8'd8;
        xmax   = r_rotation[0] ? narrow : wide;
        ymax   = r_rotation[0] ? wide : narrow;
        pix_ok = (8'(i_in.pos_x) < xmax) && (8'(i_in.pos_y) < ymax)
                 && (map_line < LINES8);
        line_ok = (8'(i_in.line_index) < LINES8);
    end

    // ------------------------------------------------------------------
    // Read-modify decision on the registered store data.
    // ------------------------------------------------------------------
    logic [7:0] cur_line, bit_mask;
    logic       cur_bit, want_bit;

    always_comb begin
        cur_line = r_rd_vld ? r_rd_mem : 8'd0;
        bit_mask = 8'd1 << r_bit;
        cur_bit  = |(cur_line & bit_mask);
        unique case (r_action)
            ACT_ON:  want_bit = 1'b1;
            ACT_OFF: want_bit = 1'b0;
            default: want_bit = ~cur_bit;
        endcase
    end

    // Chain word for a given unit; shared by every emit step.
    function automatic logic [12:0] chain_word(input logic [UNIT_W-1:0] unit,
                                               input logic [LINE_W-1:0] line,
                                               input logic [7:0] bits);
        logic hit;
        hit = ((8'(line) >> 3) == 8'(unit));
        chain_word = {hit ? (4'd1 + 4'(line[2:0])) : REG_NOOP,
                      hit ? bits : 8'd0,
                      (unit == '0)};
    endfunction

    logic [UNIT_W-1:0] n_unit;
    logic [12:0]       n_word;

    always_comb begin
        n_unit = (r_state == S_WRITE) ? UNIT_W'(UNITS - 1) : r_unit - UNIT_W'(1);
        n_word = chain_word(n_unit, r_line, r_new);
    end

    // ------------------------------------------------------------------
    // Line store memory.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[r_line] <= r_new;
        end
        r_rd_mem <= r_mem[r_line];
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rotation  <= 2'd0;
            r_side      <= 1'b0;
            r_reverse   <= 1'b0;
            r_hold      <= 1'b0;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_unit      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROTATION: r_rotation <= i_cfg_data;
                    CFG_SIDE:     r_side     <= i_cfg_data[0];
                    CFG_REVERSE:  r_reverse  <= i_cfg_data[0];
                    CFG_HOLD:     r_hold     <= i_cfg_data[0];
                endcase
            end
            r_rd_vld <= r_valid[r_line];

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_action <= t_action'(i_in.action);
                        r_new    <= i_in.line_bits;
                        if (t_action'(i_in.action) == ACT_LINE) begin
                            r_line <= LINE_W'(i_in.line_index);
                            if (line_ok) begin
                                r_state <= S_WRITE;
                            end
                        end else begin
                            r_line <= LINE_W'(map_line);
                            r_bit  <= map_bit;
                            if (pix_ok) begin
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_new <= cur_line ^ bit_mask;
                    r_state <= (cur_bit == want_bit) ? S_IDLE : S_WRITE;
                end
                S_WRITE: begin
                    r_valid[r_line] <= 1'b1;
                    if (r_hold) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_unit      <= n_unit;
                        {r_out_addr, r_out_value, r_out_mark} <= n_word;
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        if (r_unit == '0) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_unit <= n_unit;
                            {r_out_addr, r_out_value, r_out_mark} <= n_word;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.reg_addr  = r_out_addr;
    assign o_out.reg_value = r_out_value;
    assign o_out.load_mark = r_out_mark;

`ifndef SYNTHESIS
    // Output words appear only while the sequencer is emitting.
    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == S_EMIT))
        else $error("chain word outside emit phase");

    // Requests and chain words never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("ready while chain words pending");

    // A taken load mark ends the transaction.
    a_mark_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.load_mark) |=> !o_out.valid)
        else $error("words continue after load mark");

    // An accepted in-range request drops ready right after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (r_state == S_IDLE)
         && ((i_in.action == ACT_LINE && line_ok) || (i_in.action != ACT_LINE && pix_ok)))
        |=> !i_in.ready)
        else $error("ready right after taking a request");
`endif

endmodule
